@@ rtl/core/ddm_pkg.sv @@
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared widths, constants and operation codes of the differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

    // duty magnitude width; the full-scale value is all ones in that width
    localparam int DUTY_W     = 10;
    localparam int DUTY_MAX   = (2 ** DUTY_W) - 1;
    // signed command width, one sign bit over the duty width
    localparam int CMD_W      = DUTY_W + 1;
    // speed times turn factor product width
    localparam int PROD_W     = 2 * DUTY_W;
    // wheel pulse counter width, wraps as two's complement
    localparam int COUNT_BITS = 8;

    // input stream: op travels in tuser, speed_cmd and turn_cmd packed
    // in tdata from bit 0 up
    localparam int OP_W       = 2;
    localparam int IN_BITS    = 2 * CMD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // output stream: left_duty, left_reverse, right_duty, right_reverse,
    // left_pulses, right_pulses packed from bit 0 up
    localparam int OUT_BITS    = 2 * (DUTY_W + 1) + 2 * COUNT_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_MOVE       = 2'd0,
        OP_LEFT_PULSE = 2'd1,
        OP_RIGHT_PULSE = 2'd2,
        OP_READ_CLEAR = 2'd3
    } op_t;

    // one result item
    typedef struct packed {
        logic signed [COUNT_BITS-1:0] right_pulses;
        logic signed [COUNT_BITS-1:0] left_pulses;
        logic                         right_reverse;
        logic [DUTY_W-1:0]            right_duty;
        logic                         left_reverse;
        logic [DUTY_W-1:0]            left_duty;
    } result_t;

endpackage

@@ rtl/core/differential_drive_mixer_with_encoders_top.sv @@
// Two-wheel differential drive mixer with wheel pulse counters. Each input
// transfer carries one operation in tuser: a move command (speed and turn in
// tdata, each clamped to +/-1023), a left or right encoder pulse, or a read that
// returns and clears both pulse counts. Every transfer yields exactly one result
// transfer with both wheel duties, both direction bits and both counts. Result
// valid rises when an item moves on from the input register into the result
// register, and one item is taken every cycle while results are drained: the
// input register feeds a single 10x10 multiply plus a divide-by-1023 correction
// step, which lands in the result register together with the wheel state
// update. The result register holds while the output side stalls, and the input
// side keeps taking a transfer whenever the input register is empty or its
// item moves on into a result register that is free or being drained.
// ----------------------------------------------------------------------------
// differential_drive_mixer_with_encoders_top
// Speed/turn mixer for two PWM wheels with signed encoder pulse counters.
// ----------------------------------------------------------------------------
module differential_drive_mixer_with_encoders_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // speed_cmd[10:0], turn_cmd[21:11], zero fill above
    input  logic [ddm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op[1:0]
    input  logic [ddm_pkg::OP_W-1:0]          s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // left_duty[9:0], left_reverse[10], right_duty[20:11], right_reverse[21],
    // left_pulses[29:22], right_pulses[37:30], zero fill above
    output logic [ddm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import ddm_pkg::*;

    // input register
    logic                    in_valid_reg;
    op_t                     in_op_reg;
    logic signed [CMD_W-1:0] in_speed_reg;
    logic signed [CMD_W-1:0] in_turn_reg;

    // result register
    logic                    out_valid_reg;
    result_t                 out_data_reg;
    result_t                 out_data_next;

    // wheel state
    logic [DUTY_W-1:0]           left_duty_reg,  left_duty_next;
    logic [DUTY_W-1:0]           right_duty_reg, right_duty_next;
    logic                        left_dir_reg,   left_dir_next;
    logic                        right_dir_reg,  right_dir_next;
    logic signed [COUNT_BITS-1:0] left_count_reg,  left_count_next;
    logic signed [COUNT_BITS-1:0] right_count_reg, right_count_next;
    logic signed [COUNT_BITS-1:0] left_count_upd;
    logic signed [COUNT_BITS-1:0] right_count_upd;

    // mixer datapath
    logic              advance;
    logic [CMD_W-1:0]  speed_abs;
    logic [CMD_W-1:0]  turn_abs;
    logic [DUTY_W-1:0] spd_mag;
    logic [DUTY_W-1:0] trn_mag;
    logic [CMD_W-1:0]  trn_dbl;
    logic              fac_neg;
    logic [CMD_W-1:0]  fac_wide;
    logic [DUTY_W-1:0] fac_mag;
    logic [PROD_W-1:0] prod;
    logic [DUTY_W-1:0] quo_lo;
    logic [DUTY_W:0]   rem_est;
    logic [DUTY_W-1:0] quo;
    logic              spd_neg;
    logic              trn_neg;
    logic              red_neg;
    logic [DUTY_W-1:0] left_mag;
    logic [DUTY_W-1:0] right_mag;
    logic              left_neg;
    logic              right_neg;

    // handshake: move an item to the result register when it is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg    <= op_t'(s_axis_tuser);
            in_speed_reg <= s_axis_tdata[0 +: CMD_W];
            in_turn_reg  <= s_axis_tdata[CMD_W +: CMD_W];
        end
    end

    // magnitudes with clamp of the most negative code to full scale
    always_comb
    begin
        spd_neg   = in_speed_reg[CMD_W-1];
        trn_neg   = in_turn_reg[CMD_W-1];
        speed_abs = spd_neg ? (~in_speed_reg + CMD_W'(1)) : in_speed_reg;
        turn_abs  = trn_neg ? (~in_turn_reg + CMD_W'(1)) : in_turn_reg;
        spd_mag   = (speed_abs > CMD_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                   : speed_abs[DUTY_W-1:0];
        trn_mag   = (turn_abs > CMD_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                  : turn_abs[DUTY_W-1:0];
    end

    // reduced wheel: speed * (full scale - 2 * turn) / full scale, toward zero
    always_comb
    begin
        trn_dbl  = {trn_mag, 1'b0};
        fac_neg  = trn_dbl > CMD_W'(DUTY_MAX);
        fac_wide = fac_neg ? (trn_dbl - CMD_W'(DUTY_MAX))
                           : (CMD_W'(DUTY_MAX) - trn_dbl);
        fac_mag  = fac_wide[DUTY_W-1:0];
        prod     = PROD_W'(spd_mag) * PROD_W'(fac_mag);
        // divide by 2^W - 1: high half plus one correction step
        quo_lo   = prod[PROD_W-1:DUTY_W];
        rem_est  = {1'b0, prod[DUTY_W-1:0]} + {1'b0, quo_lo};
        quo      = quo_lo + DUTY_W'(rem_est >= (DUTY_W + 1)'(DUTY_MAX));
        red_neg  = fac_neg ^ spd_neg;
    end

    // steer the reduced value to the inner wheel of the turn
    always_comb
    begin
        if (trn_neg)
        begin
            left_mag  = spd_mag;
            left_neg  = spd_neg;
            right_mag = quo;
            right_neg = red_neg;
        end
        else
        begin
            left_mag  = quo;
            left_neg  = red_neg;
            right_mag = spd_mag;
            right_neg = spd_neg;
        end
    end

    // wheel state update per operation
    always_comb
    begin
        left_duty_next  = left_duty_reg;
        right_duty_next = right_duty_reg;
        left_dir_next   = left_dir_reg;
        right_dir_next  = right_dir_reg;
        left_count_upd  = left_count_reg;
        right_count_upd = right_count_reg;
        unique case (in_op_reg)
            OP_MOVE:
            begin
                left_duty_next  = left_mag;
                right_duty_next = right_mag;
                // a zero drive keeps the previous direction
                if (left_mag != '0)
                begin
                    left_dir_next = left_neg;
                end
                if (right_mag != '0)
                begin
                    right_dir_next = right_neg;
                end
            end
            OP_LEFT_PULSE:
            begin
                left_count_upd = left_dir_reg ? (left_count_reg - COUNT_BITS'(1))
                                              : (left_count_reg + COUNT_BITS'(1));
            end
            OP_RIGHT_PULSE:
            begin
                right_count_upd = right_dir_reg ? (right_count_reg - COUNT_BITS'(1))
                                                : (right_count_reg + COUNT_BITS'(1));
            end
            OP_READ_CLEAR:
            begin
                left_count_upd  = left_count_reg;
                right_count_upd = right_count_reg;
            end
            default:
            begin
                left_count_upd  = left_count_reg;
                right_count_upd = right_count_reg;
            end
        endcase
        left_count_next  = (in_op_reg == OP_READ_CLEAR) ? '0 : left_count_upd;
        right_count_next = (in_op_reg == OP_READ_CLEAR) ? '0 : right_count_upd;
    end

    // result fields: duties after update, counts before the read clears them
    always_comb
    begin
        out_data_next.left_duty     = left_duty_next;
        out_data_next.left_reverse  = left_dir_next;
        out_data_next.right_duty    = right_duty_next;
        out_data_next.right_reverse = right_dir_next;
        out_data_next.left_pulses   = left_count_upd;
        out_data_next.right_pulses  = right_count_upd;
    end

    // wheel state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_duty_reg   <= '0;
            right_duty_reg  <= '0;
            left_dir_reg    <= 1'b0;
            right_dir_reg   <= 1'b0;
            left_count_reg  <= '0;
            right_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                left_duty_reg   <= left_duty_next;
                right_duty_reg  <= right_duty_next;
                left_dir_reg    <= left_dir_next;
                right_dir_reg   <= right_dir_next;
                left_count_reg  <= left_count_next;
                right_count_reg <= right_count_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // a read leaves both counters cleared
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OP_READ_CLEAR) |=>
            (left_count_reg == '0 && right_count_reg == '0))
        else $error("counters not cleared after read");

    // only a move changes duties and directions
    a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg != OP_MOVE) |=>
            ($stable(left_duty_reg) && $stable(right_duty_reg) &&
             $stable(left_dir_reg) && $stable(right_dir_reg)))
        else $error("wheel drive changed on a non-move operation");

    // divide-by-full-scale quotient lies within one step of the product
    a_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |->
            ((PROD_W + 1)'(prod) >= (PROD_W + 1)'(quo) * (PROD_W + 1)'(DUTY_MAX) &&
             (PROD_W + 1)'(prod) < ((PROD_W + 1)'(quo) + (PROD_W + 1)'(1)) *
                                    (PROD_W + 1)'(DUTY_MAX)))
        else $error("mixer quotient out of range");

    // a stalled result keeps the wheel state frozen
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=>
            ($stable(left_count_reg) && $stable(right_count_reg)))
        else $error("state changed while result stalled");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams move, encoder pulse and read commands into the drive mixer under
// random idling on both sides and checks every wheel report against a
// cycle-free model of the mixer, the wheel directions and the pulse counters.
// ----------------------------------------------------------------------------
module testbench;

    import ddm_pkg::*;

    localparam int LEFT_SIDE    = 0;
    localparam int RIGHT_SIDE   = 1;
    localparam int ITEM_TARGET  = 1650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int SHOW_LIMIT   = 10;

    // wheel state mirror and queue of reports still to come
    class wheel_scoreboard;
        logic [DUTY_W-1:0]     duty [2];
        logic                  reverse [2];
        logic [COUNT_BITS-1:0] count [2];
        result_t               reports_due [$];
        int                    errors;

        function new();
            for (int i = 0; i < 2; i++)
            begin
                duty[i]    = '0;
                reverse[i] = 1'b0;
                count[i]   = '0;
            end
            errors = 0;
        endfunction

        function int clamp_cmd(int v);
            if (v > DUTY_MAX)
                return DUTY_MAX;
            if (v < -DUTY_MAX)
                return -DUTY_MAX;
            return v;
        endfunction

        // duty is the magnitude, direction only moves for a nonzero drive
        function void set_wheel(int side, int v);
            int c;
            c = clamp_cmd(v);
            duty[side] = DUTY_W'(c < 0 ? -c : c);
            if (c > 0)
                reverse[side] = 1'b0;
            if (c < 0)
                reverse[side] = 1'b1;
        endfunction

        function void step_count(int side);
            if (reverse[side])
                count[side] = count[side] - 1'b1;
            else
                count[side] = count[side] + 1'b1;
        endfunction

        // accepted command: update the wheel state and queue its report
        function void note_command(op_t op, logic [IN_TDATA_W-1:0] word);
            logic signed [CMD_W-1:0] spd;
            logic signed [CMD_W-1:0] trn;
            int                      s;
            int                      t;
            int                      a;
            int                      m;
            int                      reduced;
            int                      lv;
            int                      rv;
            result_t                 r;
            spd = word[0 +: CMD_W];
            trn = word[CMD_W +: CMD_W];
            case (op)
                OP_MOVE:
                begin
                    s = clamp_cmd(int'(spd));
                    t = clamp_cmd(int'(trn));
                    if (s == 0)
                    begin
                        duty[LEFT_SIDE]  = '0;
                        duty[RIGHT_SIDE] = '0;
                    end
                    else
                    begin
                        a = s < 0 ? -s : s;
                        m = a * (t < 0 ? -t : t);
                        // signed division truncates toward zero
                        reduced = (DUTY_MAX * a - 2 * m) / DUTY_MAX;
                        if (t >= 0)
                        begin
                            lv = reduced;
                            rv = a;
                        end
                        else
                        begin
                            lv = a;
                            rv = reduced;
                        end
                        if (s < 0)
                        begin
                            lv = -lv;
                            rv = -rv;
                        end
                        set_wheel(RIGHT_SIDE, rv);
                        set_wheel(LEFT_SIDE, lv);
                    end
                end
                OP_LEFT_PULSE:  step_count(LEFT_SIDE);
                OP_RIGHT_PULSE: step_count(RIGHT_SIDE);
                default:        ;
            endcase
            r.left_duty     = duty[LEFT_SIDE];
            r.left_reverse  = reverse[LEFT_SIDE];
            r.right_duty    = duty[RIGHT_SIDE];
            r.right_reverse = reverse[RIGHT_SIDE];
            r.left_pulses   = count[LEFT_SIDE];
            r.right_pulses  = count[RIGHT_SIDE];
            // counts are reported before the clear
            if (op == OP_READ_CLEAR)
            begin
                count[LEFT_SIDE]  = '0;
                count[RIGHT_SIDE] = '0;
            end
            reports_due.push_back(r);
        endfunction

        // compare one output transfer with the oldest queued report
        function void check_report(logic [OUT_BITS-1:0] word);
            result_t got;
            result_t want;
            got = result_t'(word);
            if (reports_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("unexpected report: ld=%0d lr=%0b rd=%0d rr=%0b lp=%0d rp=%0d",
                             got.left_duty, got.left_reverse, got.right_duty,
                             got.right_reverse, got.left_pulses, got.right_pulses);
                return;
            end
            want = reports_due.pop_front();
            if (got.left_duty !== want.left_duty || got.left_reverse !== want.left_reverse ||
                got.right_duty !== want.right_duty || got.right_reverse !== want.right_reverse ||
                got.left_pulses !== want.left_pulses || got.right_pulses !== want.right_pulses)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                begin
                    $display("mismatch expected: ld=%0d lr=%0b rd=%0d rr=%0b lp=%0d rp=%0d",
                             want.left_duty, want.left_reverse, want.right_duty,
                             want.right_reverse, want.left_pulses, want.right_pulses);
                    $display("         actual:   ld=%0d lr=%0b rd=%0d rr=%0b lp=%0d rp=%0d",
                             got.left_duty, got.left_reverse, got.right_duty,
                             got.right_reverse, got.left_pulses, got.right_pulses);
                end
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    wheel_scoreboard sb = new();
    int              items_sent = 0;
    int              reports_taken = 0;
    int              idle_cycles = 0;

    differential_drive_mixer_with_encoders_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // offer one command, entered and left at a falling edge
    task automatic send_item(input op_t op, input logic signed [CMD_W-1:0] spd,
                             input logic signed [CMD_W-1:0] trn);
        int gap;
        // some stretches run with no gaps at all
        gap = ((items_sent / 150) % 5 == 4) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= IN_TDATA_W'({trn, spd});
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(op_t'(s_axis_tuser), s_axis_tdata);
        items_sent++;
        @(negedge clk);
    endtask

    // command value, biased toward the clamp edges
    function automatic logic signed [CMD_W-1:0] pick_cmd();
        logic signed [CMD_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = CMD_W'(-1024);
            1:       v = CMD_W'(-1023);
            2:       v = CMD_W'(-1);
            3:       v = CMD_W'(0);
            4:       v = CMD_W'(1);
            5:       v = CMD_W'(1023);
            default: v = CMD_W'($urandom_range(0, 2047));
        endcase
        return v;
    endfunction

    function automatic op_t pick_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7)
            return OP_MOVE;
        if (r < 12)
            return OP_LEFT_PULSE;
        if (r < 17)
            return OP_RIGHT_PULSE;
        return OP_READ_CLEAR;
    endfunction

    // long run of pulses on mostly one wheel so the counts wrap
    task automatic send_pulse_run();
        int  n;
        op_t main_side;
        op_t other_side;
        send_item(OP_MOVE, pick_cmd(), pick_cmd());
        main_side  = $urandom_range(0, 1) ? OP_LEFT_PULSE : OP_RIGHT_PULSE;
        other_side = (main_side == OP_LEFT_PULSE) ? OP_RIGHT_PULSE : OP_LEFT_PULSE;
        n = $urandom_range(130, 300);
        for (int i = 0; i < n && items_sent < ITEM_TARGET; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(other_side, pick_cmd(), pick_cmd());
            else
                send_item(main_side, pick_cmd(), pick_cmd());
        end
        send_item(OP_READ_CLEAR, pick_cmd(), pick_cmd());
    endtask

    // result side: random stalls, no-stall stretches and one long hold-off
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = ((reports_taken / 170) % 5 == 2) ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            reports_taken++;
            @(negedge clk);
            if (reports_taken == HOLD_AT)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
        end
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_report(m_axis_tdata[OUT_BITS-1:0]);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[differential_drive_mixer_with_encoders_top] ERROR");
                $finish;
            end
        end
    end

    // reset, directed commands, random commands, drain
    initial
    begin
        int mode;
        int n;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // counts at reset, pulses while forward
        send_item(OP_READ_CLEAR, 0, 0);
        send_item(OP_LEFT_PULSE, -1024, 1023);
        send_item(OP_RIGHT_PULSE, 1023, -1024);
        // zero speed with a turn keeps forward
        send_item(OP_MOVE, 0, 1023);
        send_item(OP_MOVE, 1023, 0);
        // full turn drives the reduced wheel fully reverse
        send_item(OP_MOVE, 1023, 1023);
        send_item(OP_MOVE, -1024, 0);
        // stop keeps reverse, pulses then count down at zero duty
        send_item(OP_MOVE, 0, -1024);
        send_item(OP_LEFT_PULSE, 0, 0);
        send_item(OP_RIGHT_PULSE, 0, 0);
        send_item(OP_READ_CLEAR, 1023, 1023);
        send_item(OP_MOVE, 1023, -1024);
        send_item(OP_MOVE, -1023, 1023);
        // reduced wheel truncating to zero keeps its direction
        send_item(OP_MOVE, 1, 511);
        send_item(OP_MOVE, 1, 512);
        send_item(OP_MOVE, -1, -1);
        send_item(OP_MOVE, 700, 512);
        send_item(OP_MOVE, 1023, 511);
        send_item(OP_MOVE, 1000, -700);
        send_item(OP_LEFT_PULSE, -1, -1);
        send_item(OP_RIGHT_PULSE, -1, -1);
        send_item(OP_READ_CLEAR, -1024, -1024);
        send_item(OP_MOVE, 0, 0);
        send_item(OP_READ_CLEAR, 0, 0);

        // random chunks: mixed commands or long pulse runs
        while (items_sent < ITEM_TARGET)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 2)
                send_pulse_run();
            else
            begin
                n = $urandom_range(20, 60);
                for (int i = 0; i < n && items_sent < ITEM_TARGET; i++)
                    send_item(pick_op(), pick_cmd(), pick_cmd());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("[differential_drive_mixer_with_encoders_top] OK");
        else
            $display("[differential_drive_mixer_with_encoders_top] ERROR");
        $finish;
    end

endmodule
